[rtl/rc_pkg.sv]
`default_nettype none
package rc_pkg;

  localparam int MAX_ITEMS = 64;
  localparam int IDX_W     = $clog2(MAX_ITEMS);
  localparam int CNT_W     = $clog2(MAX_ITEMS + 1);
  localparam int VAL_W     = 32;
  localparam int RANK_W    = 6;
  localparam int Q_DEPTH   = 4;
  localparam int Q_PTR_W   = $clog2(Q_DEPTH);

  typedef struct packed {
    logic signed [VAL_W-1:0] value;
    logic [IDX_W-1:0]        wr_addr;
    logic                    wr_en;
    logic                    last;
    logic                    ovf;
    logic [CNT_W-1:0]        n;
  } req_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_KRD,
    S_KLAT,
    S_SCAN,
    S_DRAIN,
    S_OUT
  } back_state_t;

endpackage
`default_nettype wire

[rtl/rc_front.sv]
`default_nettype none
module rc_front (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  input  wire logic signed [rc_pkg::VAL_W-1:0] in_value,
  input  wire logic                        in_last,
  output logic                             in_ready,
  output logic                             push,
  output rc_pkg::req_t                     push_req,
  input  wire logic                        push_ready
);

  logic [rc_pkg::CNT_W-1:0] count_r, count_nxt;
  logic                     ovf_r, ovf_nxt;
  logic                     room;

  assign in_ready = push_ready;
  assign push     = in_valid & push_ready;
  assign room     = count_r < rc_pkg::CNT_W'(rc_pkg::MAX_ITEMS);

  always_comb begin
    push_req.value   = in_value;
    push_req.wr_addr = count_r[rc_pkg::IDX_W-1:0];
    push_req.wr_en   = room;
    push_req.last    = in_last;
    push_req.ovf     = ovf_r | ~room;
    push_req.n       = room ? count_r + rc_pkg::CNT_W'(1) : count_r;
  end

  always_comb begin
    count_nxt = count_r;
    ovf_nxt   = ovf_r;
    if (push) begin
      if (in_last) begin
        count_nxt = '0;
        ovf_nxt   = 1'b0;
      end else begin
        count_nxt = push_req.n;
        ovf_nxt   = push_req.ovf;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      ovf_r   <= 1'b0;
    end else begin
      count_r <= count_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

endmodule
`default_nettype wire

[rtl/rc_queue.sv]
`default_nettype none
module rc_queue (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         push,
  input  wire rc_pkg::req_t push_req,
  output logic              push_ready,
  input  wire logic         pop,
  output rc_pkg::req_t      pop_req,
  output logic              pop_valid
);

  rc_pkg::req_t               slot_r [rc_pkg::Q_DEPTH];
  logic [rc_pkg::Q_PTR_W-1:0] wptr_r, wptr_nxt;
  logic [rc_pkg::Q_PTR_W-1:0] rptr_r, rptr_nxt;
  logic [rc_pkg::Q_PTR_W:0]   fill_r, fill_nxt;
  logic                       do_push, do_pop;

  assign push_ready = fill_r != (rc_pkg::Q_PTR_W+1)'(rc_pkg::Q_DEPTH);
  assign pop_valid  = fill_r != '0;
  assign pop_req    = slot_r[rptr_r];
  assign do_push    = push & push_ready;
  assign do_pop     = pop & pop_valid;

  always_comb begin
    wptr_nxt = do_push ? wptr_r + rc_pkg::Q_PTR_W'(1) : wptr_r;
    rptr_nxt = do_pop  ? rptr_r + rc_pkg::Q_PTR_W'(1) : rptr_r;
    fill_nxt = fill_r;
    if (do_push && !do_pop) begin
      fill_nxt = fill_r + (rc_pkg::Q_PTR_W+1)'(1);
    end else if (do_pop && !do_push) begin
      fill_nxt = fill_r - (rc_pkg::Q_PTR_W+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wptr_r] <= push_req;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      fill_r <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      fill_r <= fill_nxt;
    end
  end

endmodule
`default_nettype wire

[rtl/rc_back.sv]
`default_nettype none
module rc_back (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire rc_pkg::req_t              pop_req,
  input  wire logic                      pop_valid,
  output logic                           pop,
  output logic                           out_valid,
  output logic [rc_pkg::RANK_W-1:0]      out_rank,
  output logic                           out_last,
  output logic                           out_ovf,
  input  wire logic                      out_ready
);

  logic signed [rc_pkg::VAL_W-1:0] mem [rc_pkg::MAX_ITEMS];
  logic signed [rc_pkg::VAL_W-1:0] rd_data_r;
  logic signed [rc_pkg::VAL_W-1:0] vk_r;
  logic [rc_pkg::IDX_W-1:0]        rd_addr;

  rc_pkg::back_state_t state_r, state_nxt;

  logic [rc_pkg::IDX_W-1:0]  k_r, j_r;
  logic [rc_pkg::CNT_W-1:0]  n_r, n_last;
  logic                      seq_ovf_r;
  logic [rc_pkg::RANK_W-1:0] cnt_r;
  logic                      cmp_vld_r;
  logic                      k_end, j_end, start, load;
  logic                      out_valid_r, out_last_r, out_ovf_r;
  logic [rc_pkg::RANK_W-1:0] out_rank_r;

  assign n_last = n_r - rc_pkg::CNT_W'(1);
  assign k_end  = {1'b0, k_r} == n_last;
  assign j_end  = {1'b0, j_r} == n_last;
  assign start  = pop_valid && pop_req.last && (pop_req.n != '0);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      rc_pkg::S_IDLE:  if (pop_valid && start) state_nxt = rc_pkg::S_KRD;
      rc_pkg::S_KRD:   state_nxt = rc_pkg::S_KLAT;
      rc_pkg::S_KLAT:  state_nxt = rc_pkg::S_SCAN;
      rc_pkg::S_SCAN:  if (j_end) state_nxt = rc_pkg::S_DRAIN;
      rc_pkg::S_DRAIN: state_nxt = rc_pkg::S_OUT;
      rc_pkg::S_OUT: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = k_end ? rc_pkg::S_IDLE : rc_pkg::S_KRD;
        end
      end
      default: state_nxt = rc_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    pop     = 1'b0;
    load    = 1'b0;
    rd_addr = k_r;
    case (state_r)
      rc_pkg::S_IDLE:  pop = pop_valid;
      rc_pkg::S_KRD:   rd_addr = k_r;
      rc_pkg::S_KLAT:  rd_addr = k_r;
      rc_pkg::S_SCAN:  rd_addr = j_r;
      rc_pkg::S_DRAIN: rd_addr = j_r;
      rc_pkg::S_OUT:   load = !out_valid_r || out_ready;
      default: pop = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (pop && pop_req.wr_en) begin
      mem[pop_req.wr_addr] <= pop_req.value;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (pop && start) begin
      n_r       <= pop_req.n;
      seq_ovf_r <= pop_req.ovf;
    end
    if (state_r == rc_pkg::S_KLAT) begin
      vk_r <= rd_data_r;
    end
    if (load) begin
      out_rank_r <= cnt_r;
      out_last_r <= k_end;
      out_ovf_r  <= seq_ovf_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rc_pkg::S_IDLE;
      k_r         <= '0;
      j_r         <= '0;
      cnt_r       <= '0;
      cmp_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      cmp_vld_r <= state_r == rc_pkg::S_SCAN;
      if (state_r == rc_pkg::S_IDLE) begin
        k_r <= '0;
      end else if (load) begin
        k_r <= k_r + rc_pkg::IDX_W'(1);
      end
      if (state_r == rc_pkg::S_SCAN) begin
        j_r <= j_r + rc_pkg::IDX_W'(1);
      end else begin
        j_r <= '0;
      end
      if (state_r == rc_pkg::S_KRD) begin
        cnt_r <= '0;
      end else if (cmp_vld_r && (rd_data_r < vk_r)) begin
        cnt_r <= cnt_r + rc_pkg::RANK_W'(1);
      end
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_rank  = out_rank_r;
  assign out_last  = out_last_r;
  assign out_ovf   = out_ovf_r;

endmodule
`default_nettype wire

[rtl/rank_compression.sv]
`default_nettype none
// Ranks one sequence of signed 32-bit values (up to 64; later values are dropped
// and every result of that sequence carries the overflow flag in out_tuser).
// Values are taken one a cycle while the queue has room, into a four-entry
// request queue; on the value marked tlast the block reports, in arrival order,
// each stored value's rank, the count of stored values strictly below it, with
// tlast on the final one. Ranking speed is set by the single read port of the
// value memory, which is swept once per result. New values keep entering until
// the queue fills while a sequence is being ranked.
module rank_compression (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // [31:0] value
  input  wire logic        in_tlast,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [7:0]       out_tdata,  // [5:0] rank, [7:6] zero
  output logic             out_tlast,
  output logic             out_tuser   // [0] overflow
);

  rc_pkg::req_t              push_req, pop_req;
  logic                      push, push_ready, pop, pop_valid;
  logic [rc_pkg::RANK_W-1:0] rank;

  rc_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_value   (in_tdata),
    .in_last    (in_tlast),
    .in_ready   (in_tready),
    .push       (push),
    .push_req   (push_req),
    .push_ready (push_ready)
  );

  rc_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_req   (push_req),
    .push_ready (push_ready),
    .pop        (pop),
    .pop_req    (pop_req),
    .pop_valid  (pop_valid)
  );

  rc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_req   (pop_req),
    .pop_valid (pop_valid),
    .pop       (pop),
    .out_valid (out_tvalid),
    .out_rank  (rank),
    .out_last  (out_tlast),
    .out_ovf   (out_tuser),
    .out_ready (out_tready)
  );

  assign out_tdata = {(8 - rc_pkg::RANK_W)'(0), rank};

endmodule
`default_nettype wire

[rtl/rc_checker.sv]
`default_nettype none
module rc_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [7:0]  out_tdata,
  input wire logic        out_tlast,
  input wire logic        out_tuser
);

  logic mid_r, ovf_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mid_r <= 1'b0;
      ovf_r <= 1'b0;
    end else if (out_tvalid && out_tready) begin
      mid_r <= !out_tlast;
      ovf_r <= out_tuser;
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)
      && $stable(out_tlast) && $stable(out_tuser))
    else $error("result changed while stalled");

  a_pad: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[7:6] == 2'b00)
    else $error("padding bits set");

  a_ovf_seq: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && mid_r |-> out_tuser == ovf_r)
    else $error("overflow flag changed within a sequence");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind rank_compression rc_checker u_rc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast),
  .out_tuser  (out_tuser)
);
`default_nettype wire
